// ===== src/utf8_codepoint_encoder_top_macros.svh =====
// Assertion macros for the UTF-8 code point encoder.
// Included by the modules that assert; no other dependencies.
`ifndef UTF8_CODEPOINT_ENCODER_TOP_MACROS_SVH
`define UTF8_CODEPOINT_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked in the same cycle
`define U8E_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8e check failed");
// Implication checked in the next cycle
`define U8E_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8e check failed");
`else
`define U8E_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define U8E_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== src/u8e_pkg.sv =====
// Shared types, constants and length classification for the UTF-8 encoder.
// No dependencies.
package u8e_pkg;

   typedef logic [31:0] code_point_type;
   typedef logic [7:0]  byte_type;
   // Sequence length; zero marks a value outside the encodable range
   typedef logic [2:0]  len_type;
   typedef logic [2:0]  idx_type;

   localparam len_type LEN_ERR = 3'd0;
   localparam len_type LEN_1   = 3'd1;
   localparam len_type LEN_2   = 3'd2;
   localparam len_type LEN_3   = 3'd3;
   localparam len_type LEN_4   = 3'd4;
   localparam len_type LEN_5   = 3'd5;
   localparam len_type LEN_6   = 3'd6;

   localparam code_point_type LIMIT_1 = 32'h0000_007F;
   localparam code_point_type LIMIT_2 = 32'h0000_07FF;
   localparam code_point_type LIMIT_3 = 32'h0000_FFFF;
   localparam code_point_type LIMIT_4 = 32'h001F_FFFF;
   localparam code_point_type LIMIT_5 = 32'h03FF_FFFF;
   localparam code_point_type LIMIT_6 = 32'h7FFF_FFFF;

   localparam byte_type CONT_MARK = 8'h80;
   localparam byte_type CONT_MASK = 8'h3F;

   // One result word
   typedef struct packed {
      byte_type out_byte;
      logic     is_last;
      logic     error;
   } byte_info_type;

   // Pick the shortest legacy length from the range limits
   function automatic len_type classify_len(input code_point_type cp);
      len_type len;
      priority if (cp <= LIMIT_1) len = LEN_1;
      else if (cp <= LIMIT_2) len = LEN_2;
      else if (cp <= LIMIT_3) len = LEN_3;
      else if (cp <= LIMIT_4) len = LEN_4;
      else if (cp <= LIMIT_5) len = LEN_5;
      else if (cp <= LIMIT_6) len = LEN_6;
      else len = LEN_ERR;
      return len;
   endfunction

   // Length marker of the lead byte
   function automatic byte_type lead_mark(input len_type len);
      byte_type mark;
      unique case (len)
         LEN_2:   mark = 8'hC0;
         LEN_3:   mark = 8'hE0;
         LEN_4:   mark = 8'hF0;
         LEN_5:   mark = 8'hF8;
         LEN_6:   mark = 8'hFC;
         default: mark = 8'h00;
      endcase
      return mark;
   endfunction

   // Payload bits left in the lead byte
   function automatic byte_type lead_mask(input len_type len);
      byte_type mask;
      unique case (len)
         LEN_1:   mask = 8'h7F;
         LEN_2:   mask = 8'h1F;
         LEN_3:   mask = 8'h0F;
         LEN_4:   mask = 8'h07;
         LEN_5:   mask = 8'h03;
         LEN_6:   mask = 8'h01;
         default: mask = 8'h00;
      endcase
      return mask;
   endfunction

endpackage

// ===== src/u8e_req_if.sv =====
// Input channel of the UTF-8 encoder: one code point per word.
// Depends on u8e_pkg.
interface u8e_req_if;
   import u8e_pkg::*;

   logic           valid;
   logic           ready;
   code_point_type code_point;

   modport source (output valid, output code_point, input ready);
   modport sink   (input valid, input code_point, output ready);
endinterface

// ===== src/u8e_rsp_if.sv =====
// Result channel of the UTF-8 encoder: one encoded byte per word.
// Depends on u8e_pkg.
interface u8e_rsp_if;
   import u8e_pkg::*;

   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     is_last;
   logic     error;

   modport source (output valid, output out_byte, output is_last, output error, input ready);
   modport sink   (input valid, input out_byte, input is_last, input error, output ready);
endinterface

// ===== src/utf8_codepoint_encoder_top.sv =====
// Top level of the UTF-8 code point encoder (legacy form, up to six bytes).
// Depends on u8e_pkg, u8e_req_if, u8e_rsp_if, u8e_byte_sel and the macro header.
//
//   channel  dir  word                               handshake
//   req_ch   in   code_point[31:0]                   valid/ready
//   rsp_ch   out  out_byte[7:0], is_last, error      valid/ready
//
// A code point of length L gives L result words, one byte per cycle at the
// result register while rsp_ch does not stall; out-of-range values give one.
// The next code point is taken in the cycle its predecessor's last byte
// moves into the result register, so bytes stream without gaps.
// A stall on rsp_ch holds the result register and the byte counter.
// Reset is synchronous and clears the busy flag and the result valid.
`include "utf8_codepoint_encoder_top_macros.svh"

module utf8_codepoint_encoder_top (
   input logic       clock,
   input logic       reset,
   u8e_req_if.sink   req_ch,
   u8e_rsp_if.source rsp_ch
);
   import u8e_pkg::*;

   code_point_type cp_ff;
   len_type        len_ff;
   idx_type        idx_ff;
   logic           busy_ff;
   logic           rsp_valid_ff;
   byte_info_type  rsp_ff;
   byte_info_type  cur;
   logic           req_fire;
   logic           load;

   // Form the byte the counter points at
   u8e_byte_sel u_byte_sel (
      .cp   (cp_ff),
      .len  (len_ff),
      .idx  (idx_ff),
      .info (cur)
   );

   // Advance when the result register is free or being drained
   assign load     = busy_ff & (~rsp_valid_ff | rsp_ch.ready);
   assign req_fire = req_ch.valid & req_ch.ready;
   assign req_ch.ready = ~busy_ff | (load & cur.is_last);

   // Hold the code point and step through its bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else if (req_fire) begin
         busy_ff <= 1'b1;
         idx_ff  <= 3'd0;
      end else if (load & cur.is_last) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         idx_ff  <= 3'(idx_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cp_ff  <= req_ch.code_point;
         len_ff <= classify_len(req_ch.code_point);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= cur;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_ff.out_byte;
   assign rsp_ch.is_last  = rsp_ff.is_last;
   assign rsp_ch.error    = rsp_ff.error;

   // Checks
   `U8E_ASSERT_SAME(a_idx_in_range, clock, reset, busy_ff && len_ff != LEN_ERR, idx_ff < len_ff)
   `U8E_ASSERT_SAME(a_err_single, clock, reset, rsp_valid_ff && rsp_ff.error, rsp_ff.is_last && rsp_ff.out_byte == 8'h00)
   `U8E_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, busy_ff && idx_ff == 3'd0)
   `U8E_ASSERT_NEXT(a_mid_stays_busy, clock, reset, load && !cur.is_last, busy_ff && rsp_valid_ff)
endmodule

// ===== src/u8e_byte_sel.sv =====
// Forms byte number idx of a code point's sequence, given its length.
// Depends on u8e_pkg.
module u8e_byte_sel (
   input  u8e_pkg::code_point_type cp,
   input  u8e_pkg::len_type        len,
   input  u8e_pkg::idx_type        idx,
   output u8e_pkg::byte_info_type  info
);
   import u8e_pkg::*;

   idx_type  last_idx;
   idx_type  field_idx;
   byte_type field;

   // Position of the final byte, and of the six-bit group this byte carries
   assign last_idx  = 3'(len - LEN_1);
   assign field_idx = 3'(last_idx - idx);

   // Select the group, with the bits above it for the one-byte lead
   always_comb begin
      unique case (field_idx)
         3'd0:    field = cp[7:0];
         3'd1:    field = cp[13:6];
         3'd2:    field = cp[19:12];
         3'd3:    field = cp[25:18];
         3'd4:    field = cp[31:24];
         3'd5:    field = {6'b0, cp[31:30]};
         default: field = 8'h00;
      endcase
   end

   // Build lead, continuation or error word
   always_comb begin
      if (len == LEN_ERR) begin
         info.out_byte = 8'h00;
         info.is_last  = 1'b1;
         info.error    = 1'b1;
      end else begin
         if (idx == 3'd0) begin
            info.out_byte = (field & lead_mask(len)) | lead_mark(len);
         end else begin
            info.out_byte = (field & CONT_MASK) | CONT_MARK;
         end
         info.is_last = (idx == last_idx);
         info.error   = 1'b0;
      end
   end
endmodule
